/* src/pkd_pkg.sv */
// Shared constants and payload types for the Philox key derivation pipeline.
package pkd_pkg;

  localparam int ROUNDS_DEF = 10;

  // Philox4x32 round multipliers and Weyl key increments.
  localparam logic [31:0] PX_M0 = 32'hD251_1F53;
  localparam logic [31:0] PX_M1 = 32'hCD9E_8D57;
  localparam logic [31:0] PX_W0 = 32'h9E37_79B9;
  localparam logic [31:0] PX_W1 = 32'hBB67_AE85;

  typedef struct packed {
    logic [63:0] seed;
    logic [63:0] offset;
    logic [63:0] increment;
  } pkd_in_t;

  typedef struct packed {
    logic [63:0] new_seed;
    logic [63:0] new_offset;
  } pkd_out_t;

  // State between two pipeline stages: the two raw products of the last round,
  // the pass-through counter words and the key that round used.
  typedef struct packed {
    logic [63:0] p0;
    logic [63:0] p1;
    logic [31:0] c1;
    logic [31:0] c3;
    logic [31:0] k0;
    logic [31:0] k1;
  } pkd_lane_t;

endpackage

/* src/pkd_prep.sv */
// Input stage: forms the counter and key and seeds the first round stage.
module pkd_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pkd_pkg::pkd_in_t    in_word,
  output logic                vld_o,
  input  logic                rdy_i,
  output pkd_pkg::pkd_lane_t  lane_o
);

  logic               vld_r;
  pkd_pkg::pkd_lane_t lane_r;
  pkd_pkg::pkd_lane_t lane_nxt;
  logic [63:0]        sum;
  logic [31:0]        kpre0;
  logic [31:0]        kpre1;

  // The key is stored one Weyl step behind, and the counter words are encoded
  // so that the generic round stage reproduces counter (sum lo, sum hi, 0, 0)
  // with the unbumped seed as the first round key.
  always_comb begin
    sum          = in_word.offset + in_word.increment;
    kpre0        = in_word.seed[31:0] - pkd_pkg::PX_W0;
    kpre1        = in_word.seed[63:32] - pkd_pkg::PX_W1;
    lane_nxt.p0  = 64'd0;
    lane_nxt.p1  = {32'd0, sum[63:32]};
    lane_nxt.c1  = sum[31:0] ^ kpre0;
    lane_nxt.c3  = kpre1;
    lane_nxt.k0  = kpre0;
    lane_nxt.k1  = kpre1;
  end

  assign in_ready = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      lane_r <= lane_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign lane_o = lane_r;

endmodule

/* src/pkd_round.sv */
// One Philox4x32 round stage: finish the previous round, bump the key, multiply.
module pkd_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  output logic                rdy_o,
  input  pkd_pkg::pkd_lane_t  lane_i,
  output logic                vld_o,
  input  logic                rdy_i,
  output pkd_pkg::pkd_lane_t  lane_o
);

  logic               vld_r;
  pkd_pkg::pkd_lane_t lane_r;
  pkd_pkg::pkd_lane_t lane_nxt;
  logic [31:0]        n0;
  logic [31:0]        n2;

  always_comb begin
    n0          = lane_i.p1[63:32] ^ lane_i.c1 ^ lane_i.k0;
    n2          = lane_i.p0[63:32] ^ lane_i.c3 ^ lane_i.k1;
    lane_nxt.p0 = {32'd0, pkd_pkg::PX_M0} * {32'd0, n0};
    lane_nxt.p1 = {32'd0, pkd_pkg::PX_M1} * {32'd0, n2};
    lane_nxt.c1 = lane_i.p1[31:0];
    lane_nxt.c3 = lane_i.p0[31:0];
    lane_nxt.k0 = lane_i.k0 + pkd_pkg::PX_W0;
    lane_nxt.k1 = lane_i.k1 + pkd_pkg::PX_W1;
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      lane_r <= lane_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign lane_o = lane_r;

endmodule

/* src/pkd_final.sv */
// Output stage: completes the last round and holds the result word.
module pkd_final (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  output logic                rdy_o,
  input  pkd_pkg::pkd_lane_t  lane_i,
  output logic                out_valid,
  input  logic                out_ready,
  output pkd_pkg::pkd_out_t   out_word
);

  logic              vld_r;
  pkd_pkg::pkd_out_t word_r;
  pkd_pkg::pkd_out_t word_nxt;

  always_comb begin
    word_nxt.new_seed   = {lane_i.p1[31:0], lane_i.p1[63:32] ^ lane_i.c1 ^ lane_i.k0};
    word_nxt.new_offset = {lane_i.p0[31:0], lane_i.p0[63:32] ^ lane_i.c3 ^ lane_i.k1};
  end

  assign rdy_o = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_word  = word_r;

endmodule

/* src/philox_key_derive.sv */
// Top level of the Philox4x32 key derivation pipeline.
//
// Each input word carries a parent seed, a parent offset and an increment
// (a split index or fold-in data). The block adds offset and increment modulo
// 2^64, runs ROUNDS rounds of Philox4x32 on counter (sum lo, sum hi, 0, 0)
// under key (seed lo, seed hi), and returns one result word with the derived
// seed (words x, y) and derived offset (words z, w).
//
// Both channels are valid/ready. The pipeline is one input stage, one stage
// per round (each holding one 32x32 multiplier pair) and one output register,
// ROUNDS + 2 registers deep. A new word can be accepted in every cycle while
// the receiver takes every result.
//
// Every stage has its own valid bit and takes a new word whenever it is empty
// or its successor moves, so bubbles close up while the receiver stalls; the
// block keeps accepting until all ROUNDS + 2 stages are full. A stalled output
// word is held unchanged until taken. Reset clears every valid bit; no state
// other than the words in flight exists.
module philox_key_derive #(
  parameter int ROUNDS = pkd_pkg::ROUNDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pkd_pkg::pkd_in_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output pkd_pkg::pkd_out_t out_word
);

  // Stage s drives vld[s] and lane[s]; rdy[s] says the next stage can take that word.
  logic               vld  [ROUNDS+1];
  logic               rdy  [ROUNDS+1];
  pkd_pkg::pkd_lane_t lane [ROUNDS+1];

  pkd_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .vld_o    (vld[0]),
    .rdy_i    (rdy[0]),
    .lane_o   (lane[0])
  );

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    pkd_round u_round (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld[r]),
      .rdy_o  (rdy[r]),
      .lane_i (lane[r]),
      .vld_o  (vld[r+1]),
      .rdy_i  (rdy[r+1]),
      .lane_o (lane[r+1])
    );
  end

  pkd_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (vld[ROUNDS]),
    .rdy_o     (rdy[ROUNDS]),
    .lane_i    (lane[ROUNDS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // An accepted word must land in the input stage.
  a_accept_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted word did not reach the input stage");

  // The input stage is never blocked while it is empty.
  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !vld[0] |-> in_ready)
    else $error("input refused while input stage empty");

  // A word in the last round stage that cannot move must stay put.
  a_last_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (vld[ROUNDS] && !rdy[ROUNDS]) |=> (vld[ROUNDS] && $stable(lane[ROUNDS])))
    else $error("last round stage lost or changed a stalled word");

  // A result only appears after the last round stage held a word.
  a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld[ROUNDS]))
    else $error("result appeared without a word in the last round stage");

endmodule
